FILE: hdl/stc_pkg.sv
// shared codes and keyword table for the shell token classifier
package stc_pkg;

	localparam int KwCount  = 20;
	localparam int KwMaxLen = 8;

	typedef logic [4:0] class_t;
	typedef logic [4:0] kw_idx_t;
	typedef logic [3:0] pos_t;
	typedef logic [7:0] char_t;
	typedef logic [KwCount-1:0] kw_mask_t;

	// token class codes
	localparam class_t CLS_LPAREN     = 5'd0;
	localparam class_t CLS_RPAREN     = 5'd1;
	localparam class_t CLS_PIPE       = 5'd2;
	localparam class_t CLS_LESS       = 5'd3;
	localparam class_t CLS_GREAT      = 5'd4;
	localparam class_t CLS_AND        = 5'd5;
	localparam class_t CLS_NEWLINE    = 5'd6;
	localparam class_t CLS_SEMI       = 5'd7;
	localparam class_t CLS_INTEGER    = 5'd8;
	localparam class_t CLS_WORD       = 5'd9;
	localparam class_t CLS_AND_GREAT  = 5'd10;
	localparam class_t CLS_AND_IF     = 5'd11;
	localparam class_t CLS_PIPE_AND   = 5'd12;
	localparam class_t CLS_OR_IF      = 5'd13;
	localparam class_t CLS_SEMI_AND   = 5'd14;
	localparam class_t CLS_SEMI_OR    = 5'd15;
	localparam class_t CLS_DSEMI      = 5'd16;
	localparam class_t CLS_DGREAT     = 5'd17;
	localparam class_t CLS_GREAT_AND  = 5'd18;
	localparam class_t CLS_CLOBBER    = 5'd19;
	localparam class_t CLS_DLESS      = 5'd20;
	localparam class_t CLS_LESS_AND   = 5'd21;
	localparam class_t CLS_LESS_GREAT = 5'd22;
	localparam class_t CLS_ASSIGN     = 5'd23;
	localparam class_t CLS_COMMENT    = 5'd24;
	localparam class_t CLS_TLESS      = 5'd25;
	localparam class_t CLS_DSEMI_AND  = 5'd26;
	localparam class_t CLS_AND_DGREAT = 5'd27;
	localparam class_t CLS_KEYWORD    = 5'd28;

	// single-character keyword slots
	localparam kw_idx_t KW_LBRACE = 5'd12;
	localparam kw_idx_t KW_RBRACE = 5'd13;
	localparam kw_idx_t KW_BANG   = 5'd14;

	// characters of interest
	localparam char_t CH_LPAREN  = 8'h28;
	localparam char_t CH_RPAREN  = 8'h29;
	localparam char_t CH_LBRACE  = 8'h7B;
	localparam char_t CH_RBRACE  = 8'h7D;
	localparam char_t CH_BANG    = 8'h21;
	localparam char_t CH_PIPE    = 8'h7C;
	localparam char_t CH_LESS    = 8'h3C;
	localparam char_t CH_GREAT   = 8'h3E;
	localparam char_t CH_AMP     = 8'h26;
	localparam char_t CH_NEWLINE = 8'h0A;
	localparam char_t CH_SEMI    = 8'h3B;
	localparam char_t CH_HASH    = 8'h23;
	localparam char_t CH_EQUALS  = 8'h3D;
	localparam char_t CH_UNDER   = 8'h5F;
	localparam char_t CH_PLUS    = 8'h2B;

	// keyword spellings, unused positions zero
	localparam char_t KW_TEXT [KwCount][KwMaxLen] = '{
		'{"i", "f", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"t", "h", "e", "n", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"e", "l", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"e", "l", "i", "f", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"f", "i", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"d", "o", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"d", "o", "n", "e", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"c", "a", "s", "e", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"e", "s", "a", "c", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"w", "h", "i", "l", "e", 8'h0, 8'h0, 8'h0},
		'{"u", "n", "t", "i", "l", 8'h0, 8'h0, 8'h0},
		'{"f", "o", "r", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"{", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"}", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"!", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"i", "n", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
		'{"s", "e", "l", "e", "c", "t", 8'h0, 8'h0},
		'{"f", "u", "n", "c", "t", "i", "o", "n"},
		'{"t", "i", "m", "e", 8'h0, 8'h0, 8'h0, 8'h0},
		'{"c", "o", "p", "r", "o", "c", 8'h0, 8'h0}
	};

	localparam pos_t KW_LEN [KwCount] = '{
		4'd2, 4'd4, 4'd4, 4'd4, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd5,
		4'd5, 4'd3, 4'd1, 4'd1, 4'd1, 4'd2, 4'd6, 4'd8, 4'd4, 4'd6
	};

	localparam pos_t POS_SAT = 4'd9;

endpackage

FILE: hdl/shell_token_classifier_top.sv
// shell token classifier: per-character state update and registered class result
//
// Usage
//   Input channel (in_valid / in_ready, char_code, last_char) takes one
//   character of a token per word. The word with last_char set ends the
//   token and yields one result word on the output channel (out_valid /
//   out_ready, token_class, keyword_index); other words yield nothing.
//   The result is registered and presented in the cycle after the final
//   character is taken. One character per cycle while in_ready is high;
//   the per-character work is a row of parallel compares against the
//   keyword table, one pass. While a result waits for the receiver, characters
//   that do not end a token are still taken; a final character is taken only
//   when the output register is free or is being emptied in the same cycle.
//   Reset clears the token state (position, flags, keyword mask) and
//   empties the output register; every token end does the same clearing
//   of the token state.
module shell_token_classifier_top
	import stc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] token_class,
	output logic [4:0] keyword_index
);

	function automatic logic is_dig(input char_t c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input char_t c);
		return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
	endfunction

	// token state
	pos_t     pos_q;
	char_t    first_q;
	char_t    second_q;
	kw_mask_t alive_q;
	logic     all_dig_q;
	logic     eq_seen_q;
	logic     name_bad_q;
	logic     plus_q;

	// result register
	logic     out_valid_q;
	class_t   class_q;
	kw_idx_t  kw_idx_q;

	// next token state
	pos_t     pos_n;
	char_t    first_n;
	char_t    second_n;
	kw_mask_t alive_n;
	logic     all_dig_n;
	logic     eq_seen_n;
	logic     name_bad_n;
	logic     plus_n;

	class_t   class_n;
	kw_idx_t  kw_idx_n;
	logic     kw_hit;
	kw_idx_t  kw_hit_idx;
	logic     accept;
	logic     emit;

	// handshake
	assign in_ready = !out_valid_q || out_ready || !last_char;
	assign accept   = in_valid && in_ready;
	assign emit     = accept && last_char;

	// state update for one character
	always_comb begin
		first_n    = (pos_q == 4'd0) ? char_code : first_q;
		second_n   = (pos_q == 4'd1) ? char_code : second_q;
		all_dig_n  = all_dig_q && is_dig(char_code);
		eq_seen_n  = eq_seen_q;
		name_bad_n = name_bad_q;
		plus_n     = plus_q;
		for (int k = 0; k < KwCount; k++) begin
			alive_n[k] = alive_q[k] && (pos_q < KW_LEN[k]) &&
				(KW_TEXT[k][pos_q[2:0]] == char_code);
		end
		if ((pos_q != 4'd0) && !eq_seen_q) begin
			if (char_code == CH_EQUALS) begin
				eq_seen_n = 1'b1;
				plus_n    = 1'b0;
			end else begin
				if (plus_q)
					name_bad_n = 1'b1;
				plus_n = (char_code == CH_PLUS);
				if ((char_code != CH_PLUS) && !is_alpha(char_code) &&
						!is_dig(char_code) && (char_code != CH_UNDER))
					name_bad_n = 1'b1;
			end
		end
		pos_n = (pos_q < POS_SAT) ? pos_q + 4'd1 : pos_q;
	end

	// first surviving keyword of the token's length
	always_comb begin
		kw_hit     = 1'b0;
		kw_hit_idx = '0;
		for (int k = KwCount - 1; k >= 0; k--) begin
			if (alive_n[k] && (KW_LEN[k] == pos_n)) begin
				kw_hit     = 1'b1;
				kw_hit_idx = kw_idx_t'(k);
			end
		end
	end

	// classification by token length
	always_comb begin
		class_n  = CLS_WORD;
		kw_idx_n = '0;
		if (pos_n == 4'd1) begin
			case (first_n)
				CH_LPAREN:  class_n = CLS_LPAREN;
				CH_RPAREN:  class_n = CLS_RPAREN;
				CH_LBRACE:  begin class_n = CLS_KEYWORD; kw_idx_n = KW_LBRACE; end
				CH_RBRACE:  begin class_n = CLS_KEYWORD; kw_idx_n = KW_RBRACE; end
				CH_BANG:    begin class_n = CLS_KEYWORD; kw_idx_n = KW_BANG; end
				CH_PIPE:    class_n = CLS_PIPE;
				CH_LESS:    class_n = CLS_LESS;
				CH_GREAT:   class_n = CLS_GREAT;
				CH_AMP:     class_n = CLS_AND;
				CH_NEWLINE: class_n = CLS_NEWLINE;
				CH_SEMI:    class_n = CLS_SEMI;
				default:    class_n = is_dig(first_n) ? CLS_INTEGER : CLS_WORD;
			endcase
		end else if (pos_n == 4'd2) begin
			case (first_n)
				CH_AMP:  class_n = (second_n == CH_GREAT) ? CLS_AND_GREAT : CLS_AND_IF;
				CH_PIPE: class_n = (second_n == CH_AMP) ? CLS_PIPE_AND : CLS_OR_IF;
				CH_SEMI: begin
					if (second_n == CH_AMP)
						class_n = CLS_SEMI_AND;
					else if (second_n == CH_PIPE)
						class_n = CLS_SEMI_OR;
					else
						class_n = CLS_DSEMI;
				end
				CH_GREAT: begin
					if (second_n == CH_GREAT)
						class_n = CLS_DGREAT;
					else if (second_n == CH_AMP)
						class_n = CLS_GREAT_AND;
					else
						class_n = CLS_CLOBBER;
				end
				CH_LESS: begin
					if (second_n == CH_LESS)
						class_n = CLS_DLESS;
					else if (second_n == CH_AMP)
						class_n = CLS_LESS_AND;
					else
						class_n = CLS_LESS_GREAT;
				end
				default: begin
					if (is_dig(first_n) && is_dig(second_n)) begin
						class_n = CLS_INTEGER;
					end else if (kw_hit) begin
						class_n  = CLS_KEYWORD;
						kw_idx_n = kw_hit_idx;
					end else if (is_alpha(first_n) && (second_n == CH_EQUALS)) begin
						class_n = CLS_ASSIGN;
					end else begin
						class_n = CLS_WORD;
					end
				end
			endcase
		end else begin
			if (first_n == CH_HASH) begin
				class_n = CLS_COMMENT;
			end else if (is_dig(first_n)) begin
				class_n = all_dig_n ? CLS_INTEGER : CLS_WORD;
			end else if (is_alpha(first_n)) begin
				if (kw_hit) begin
					class_n  = CLS_KEYWORD;
					kw_idx_n = kw_hit_idx;
				end else if (eq_seen_n && !name_bad_n) begin
					class_n = CLS_ASSIGN;
				end
			end else if (pos_n == 4'd3) begin
				// three-character operators
				if ((first_n == CH_LESS) && (second_n == CH_LESS) && (char_code == CH_LESS))
					class_n = CLS_TLESS;
				else if ((first_n == CH_SEMI) && (second_n == CH_SEMI) &&
						(char_code == CH_AMP))
					class_n = CLS_DSEMI_AND;
				else if ((first_n == CH_AMP) && (second_n == CH_GREAT) &&
						(char_code == CH_GREAT))
					class_n = CLS_AND_DGREAT;
			end
		end
	end

	// token state registers, cleared at each token end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			first_q    <= '0;
			second_q   <= '0;
			alive_q    <= '1;
			all_dig_q  <= 1'b1;
			eq_seen_q  <= 1'b0;
			name_bad_q <= 1'b0;
			plus_q     <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				pos_q      <= '0;
				first_q    <= '0;
				second_q   <= '0;
				alive_q    <= '1;
				all_dig_q  <= 1'b1;
				eq_seen_q  <= 1'b0;
				name_bad_q <= 1'b0;
				plus_q     <= 1'b0;
			end else begin
				pos_q      <= pos_n;
				first_q    <= first_n;
				second_q   <= second_n;
				alive_q    <= alive_n;
				all_dig_q  <= all_dig_n;
				eq_seen_q  <= eq_seen_n;
				name_bad_q <= name_bad_n;
				plus_q     <= plus_n;
			end
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (emit) begin
			class_q  <= class_n;
			kw_idx_q <= kw_idx_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign token_class   = class_q;
	assign keyword_index = kw_idx_q;

`ifndef SYNTHESIS
	// a token end always leaves a result in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_char) |=> out_valid)
		else $error("token end without result");

	// token state starts over after each token end
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_char) |=> (pos_q == 4'd0 && alive_q == '1))
		else $error("token state not cleared");

	// keyword index only accompanies the keyword class
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_class != CLS_KEYWORD) |-> (keyword_index == 5'd0))
		else $error("keyword index on non-keyword class");

	// position never passes its saturation point
	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_SAT)
		else $error("position overflow");
`endif

endmodule
